[hw/rtl/jrr_pkg.sv]
// Package for the Jacobi row relaxation engine: sizes, item types, mode codes.
// Used by jacobi_row_relax_csr and jrr_div under hw/rtl.
package jrr_pkg;

  localparam int ROWS      = 1024;  // power of two
  localparam int FRAC_BITS = 16;
  localparam int ADDR_W    = $clog2(ROWS);
  localparam int QCLAMP_W  = 41;    // quotient magnitude clamp is 2^40

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_NZ    = 2'd1,
    MODE_SWEEP = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef struct packed {
    logic [1:0]         mode;
    logic [9:0]         row;
    logic [9:0]         col;
    logic signed [31:0] entry_value;
    logic signed [31:0] rhs_value;
    logic signed [31:0] pivot_value;
    logic signed [31:0] start_value;
    logic               row_last;
  } jrr_in_t;

  typedef struct packed {
    logic [9:0]         out_row;
    logic signed [31:0] new_x;
    logic               zero_pivot;
    logic               saturated;
  } jrr_out_t;

  // Row field to memory index: modulo ROWS for a power-of-two ROWS.
  function automatic logic [ADDR_W-1:0] row_idx(logic [9:0] v);
    logic [ADDR_W+9:0] t;
    t = {{ADDR_W{1'b0}}, v};
    return t[ADDR_W-1:0];
  endfunction

endpackage

[hw/rtl/jacobi_row_relax_csr.sv]
// Jacobi relaxation engine for CSR rows, signed Q16.16; top level.
// Load, sweep-end and idle-mode transactions are handled at accept; a nonzero steps
// through x read, multiply, saturating accumulate. A row-last nonzero adds the x[row] read,
// the 64-step bit-serial divider and a finish state that strobes the result; no new
// transaction is taken until the engine is back in idle. A zero diagonal skips the divider.
// Results are strobed on done_o for one cycle; the receiver cannot stall.
// Reset clears control, the accumulator and the bank select; memories stay undefined.
// Depends on jrr_pkg, jrr_ram, jrr_div.
module jacobi_row_relax_csr import jrr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  jrr_in_t  in_i,
  input  logic     cfg_we_i,
  input  logic     cfg_wdata_i,
  output logic     done_o,
  output jrr_out_t res_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_ACC, S_XR, S_DIV, S_FIN
  } state_e;

  state_e state_q, state_d;
  logic   sync_q, bank_q, open_q, open_d;
  logic   done_q, done_d;
  jrr_out_t res_q, res_d;
  logic signed [63:0] acc_q, acc_d, prod_q;
  logic signed [31:0] entry_q, xold_q, diag_q;
  logic [9:0] row_q;
  logic       last_q, neg_q, zp_q;
  logic       div_done;
  logic       dstart_q, dstart_d;
  logic [63:0] quo, anum;
  logic [31:0] aden;

  logic accept, load_we, fin_we, wr_bank;
  logic [ADDR_W-1:0] xr_addr, w_addr, rc_addr;
  logic [31:0] xa_rd, xb_rd, x_rd, rhs_rd, diag_rd, wdata;
  logic we_a, we_b;

  assign accept  = start && (state_q == S_IDLE);
  assign busy    = (state_q != S_IDLE);
  assign load_we = accept && (in_i.mode == MODE_LOAD);
  assign fin_we  = (state_q == S_FIN);
  assign wr_bank = sync_q ? !bank_q : bank_q;

  assign xr_addr = (state_q == S_IDLE) ? row_idx(in_i.col) : row_idx(row_q);
  // hold the row address after accept, the input may move on
  assign rc_addr = (state_q == S_IDLE) ? row_idx(in_i.row) : row_idx(row_q);
  assign w_addr  = load_we ? row_idx(in_i.row) : row_idx(row_q);
  assign wdata   = load_we ? in_i.start_value : res_d.new_x;
  assign we_a    = load_we || (fin_we && !wr_bank);
  assign we_b    = load_we || (fin_we && wr_bank);
  assign x_rd    = bank_q ? xb_rd : xa_rd;

  jrr_ram #(.WIDTH(32), .DEPTH(ROWS)) u_bank_a (
    .clk_i, .we_i(we_a), .waddr_i(w_addr), .wdata_i(wdata),
    .raddr_i(xr_addr), .rdata_o(xa_rd));
  jrr_ram #(.WIDTH(32), .DEPTH(ROWS)) u_bank_b (
    .clk_i, .we_i(we_b), .waddr_i(w_addr), .wdata_i(wdata),
    .raddr_i(xr_addr), .rdata_o(xb_rd));
  jrr_ram #(.WIDTH(32), .DEPTH(ROWS)) u_rhs (
    .clk_i, .we_i(load_we), .waddr_i(w_addr), .wdata_i(in_i.rhs_value),
    .raddr_i(rc_addr), .rdata_o(rhs_rd));
  jrr_ram #(.WIDTH(32), .DEPTH(ROWS)) u_diag (
    .clk_i, .we_i(load_we), .waddr_i(w_addr), .wdata_i(in_i.pivot_value),
    .raddr_i(rc_addr), .rdata_o(diag_rd));

  // magnitudes for the divider
  assign anum = acc_q[63] ? (64'd0 - acc_q) : acc_q;
  assign aden = diag_q[31] ? (32'd0 - diag_q) : diag_q;

  jrr_div u_div (
    .clk_i, .rst_ni, .start_i(dstart_q), .done_o(div_done),
    .num_i(anum), .den_i(aden), .quo_o(quo));

  logic signed [63:0] base;
  logic signed [64:0] diff;
  logic [QCLAMP_W-1:0] qmag;
  logic signed [42:0]  qs, sum;

  always_comb begin
    base = open_q ? acc_q
                  : ($signed({{32{rhs_rd[31]}}, rhs_rd}) <<< FRAC_BITS);
    diff = {base[63], base} - {prod_q[63], prod_q};
    qmag = (quo > (64'd1 << 40)) ? QCLAMP_W'(64'd1 << 40) : quo[QCLAMP_W-1:0];
    qs   = neg_q ? -$signed({2'b00, qmag}) : $signed({2'b00, qmag});
    sum  = $signed({{11{xold_q[31]}}, xold_q}) + qs;

    state_d  = state_q;
    open_d   = open_q;
    acc_d    = acc_q;
    dstart_d = 1'b0;
    done_d   = 1'b0;
    res_d    = res_q;
    res_d.out_row = row_q;
    if (zp_q) begin
      res_d.new_x      = xold_q;
      res_d.zero_pivot = 1'b1;
      res_d.saturated  = 1'b0;
    end else begin
      res_d.zero_pivot = 1'b0;
      if (sum > 43'sd2147483647) begin
        res_d.new_x = 32'h7fffffff; res_d.saturated = 1'b1;
      end else if (sum < -43'sd2147483648) begin
        res_d.new_x = 32'h80000000; res_d.saturated = 1'b1;
      end else begin
        res_d.new_x = sum[31:0]; res_d.saturated = 1'b0;
      end
    end

    case (state_q)
      S_IDLE: if (accept && in_i.mode == MODE_NZ) state_d = S_MUL;
      S_MUL:  state_d = S_ACC;
      S_ACC: begin
        open_d = 1'b1;
        if (diff[64] != diff[63]) acc_d = diff[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        else acc_d = diff[63:0];
        state_d = last_q ? S_XR : S_IDLE;
      end
      S_XR: begin
        if (diag_q == 32'sd0) state_d = S_FIN;
        else begin
          dstart_d = 1'b1;
          state_d  = S_DIV;
        end
      end
      S_DIV: if (div_done) state_d = S_FIN;
      S_FIN: begin
        done_d  = 1'b1;
        open_d  = 1'b0;
        acc_d   = '0;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      sync_q   <= 1'b1;
      bank_q   <= 1'b0;
      open_q   <= 1'b0;
      acc_q    <= '0;
      dstart_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      open_q   <= open_d;
      acc_q    <= acc_d;
      dstart_q <= dstart_d;
      done_q   <= done_d;
      if (cfg_we_i) sync_q <= cfg_wdata_i;
      if (accept && in_i.mode == MODE_SWEEP && sync_q) bank_q <= !bank_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      entry_q <= in_i.entry_value;
      row_q   <= in_i.row;
      last_q  <= in_i.row_last;
    end
    if (state_q == S_MUL) begin
      prod_q <= entry_q * $signed(x_rd);
      diag_q <= diag_rd;
    end
    if (state_q == S_XR) begin
      xold_q <= x_rd;
      zp_q   <= (diag_q == 32'sd0);
      neg_q  <= acc_q[63] ^ diag_q[31];
    end
    if (state_q == S_FIN) res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

[hw/rtl/jrr_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module jrr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[hw/rtl/jrr_div.sv]
// Radix-2 restoring divider, 64-bit magnitude by 32-bit magnitude, one bit a cycle.
// Depends on jrr_pkg.
module jrr_div import jrr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  output logic         done_o,
  input  logic [63:0]  num_i,
  input  logic [31:0]  den_i,
  output logic [63:0]  quo_o
);

  logic        run_q, run_d, done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] rem_q, rem_d, den_q, den_d;
  logic [63:0] num_q, num_d, quo_q, quo_d;
  logic [32:0] trial;

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    num_d  = num_q;
    quo_d  = quo_q;
    trial  = {rem_q, num_q[63]} - {1'b0, den_q};
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      rem_d = '0;
      den_d = den_i;
      num_d = num_i;
      quo_d = '0;
    end else if (run_q) begin
      num_d = {num_q[62:0], 1'b0};
      if (!trial[32] || rem_q[31]) begin
        rem_d = trial[31:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = {rem_q[30:0], num_q[63]};
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    num_q <= num_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
